// File: src/led_frame_power_limit_gamma_core_assert.svh
// Assertion macros for the LED frame power limiter core.
// Used by modules that check their own control logic; expects clk and rst_n in scope.
`ifndef LED_FRAME_POWER_LIMIT_GAMMA_CORE_ASSERT_SVH
`define LED_FRAME_POWER_LIMIT_GAMMA_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LFPL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LFPL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/lfpl_pkg.sv
// Shared types, constants and the gamma 2.6 table for the LED frame power limiter.
// Used by every module of the core; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfpl_pkg;

  localparam int MAX_PIXELS = 2048;
  localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W      = 21;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam int Q_W        = 18;
  localparam int EST_W      = 19;
  localparam int DIV_NW     = 26;
  localparam int DIV_DW     = 18;
  localparam int DIV_CW     = $clog2(DIV_NW);
  localparam logic [8:0] FSCALE_FULL = 9'd256;

  // sum*20/255 as (sum * 20 * ceil(2^34/255)) >> 34, exact for every 21-bit sum
  localparam int EST_SHIFT  = 34;
  localparam int EST_RCP_W  = 31;
  localparam int EST_PROD_W = SUM_W + EST_RCP_W;
  localparam logic [EST_RCP_W-1:0] EST_RECIP = 31'd1347440740;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUDGET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAMMA_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STATUS_EN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ERROR_FLAG = 3'd4;

  localparam logic OP_MEASURE = 1'b0;
  localparam logic OP_EMIT    = 1'b1;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;
  localparam int OUT_PAD_W  = OUT_DATA_W - 41;

  localparam logic [7:0] STAT_OK_R  = 8'd0;
  localparam logic [7:0] STAT_OK_G  = 8'd24;
  localparam logic [7:0] STAT_OK_B  = 8'd4;
  localparam logic [7:0] STAT_ERR_R = 8'd40;
  localparam logic [7:0] STAT_ERR_G = 8'd0;
  localparam logic [7:0] STAT_ERR_B = 8'd0;

  typedef struct packed {
    logic load_in;
    logic step1;
    logic step2;
    logic accum;
    logic div_a;
    logic eval;
    logic load_pix;
    logic load_rep;
  } lfpl_cmd_t;

  typedef struct packed {
    logic op;
    logic last;
    logic div_busy;
    logic over;
  } lfpl_sts_t;

  localparam int GAMMA_TBL_W = 256 * 8;

  // round(255*(v/255)^2.6): step g while (2g+1)^5 * 255^8 <= 32 * v^13
  function automatic logic [GAMMA_TBL_W-1:0] gamma_table();
    logic [127:0] base8;
    logic [127:0] rhs;
    logic [127:0] lhs;
    logic [GAMMA_TBL_W-1:0] tbl;
    int g;
    int v;
    int n;
    logic stop;
    base8 = 128'd1;
    for (n = 0; n < 8; n++) base8 = base8 * 128'd255;
    g = 0;
    tbl = '0;
    for (v = 0; v < 256; v++) begin
      rhs = 128'd32;
      for (n = 0; n < 13; n++) rhs = rhs * 128'(v);
      stop = 1'b0;
      while ((g < 255) && !stop) begin
        lhs = base8;
        for (n = 0; n < 5; n++) lhs = lhs * 128'(2 * g + 1);
        if (lhs > rhs) begin
          stop = 1'b1;
        end else begin
          g = g + 1;
        end
      end
      tbl[v*8 +: 8] = 8'(g);
    end
    return tbl;
  endfunction

  localparam logic [GAMMA_TBL_W-1:0] GAMMA_TBL = gamma_table();

  function automatic logic [7:0] gamma_lut(input logic [7:0] idx);
    return GAMMA_TBL[{idx, 3'b000} +: 8];
  endfunction

endpackage

`default_nettype wire

// File: src/lfpl_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on lfpl_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module lfpl_div
  import lfpl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic              busy,
  output logic [DIV_NW-1:0] quotient
);

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_DW-1:0] dsr_r;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   diff;
  logic              fits;

  assign shifted = {rem_r, quo_r[DIV_NW-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = (shifted >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CW'(DIV_NW - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_NW-2:0], fits};
      rem_r <= fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: src/lfpl_dp.sv
// Datapath: configuration registers, pixel scaling, frame accumulation, gamma and result register.
// Depends on lfpl_pkg and lfpl_div; driven by commands from lfpl_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module lfpl_dp
  import lfpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  input  lfpl_cmd_t             cmd,
  output lfpl_sts_t             sts,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tuser
);

  logic [7:0]  brightness_r;
  logic [15:0] budget_r;
  logic        gamma_en_r;
  logic        status_en_r;
  logic        error_flag_r;

  logic        op_r;
  logic        last_r;
  logic [7:0]  red_r;
  logic [7:0]  grn_r;
  logic [7:0]  blu_r;

  logic [9:0]  pix_sum_r;
  logic [8:0]  scale_r;
  logic [7:0]  ch_r_r;
  logic [7:0]  ch_g_r;
  logic [7:0]  ch_b_r;

  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] sum_r;
  logic [8:0]       frame_scale_r;
  logic [15:0]      est_r;
  logic             limited_r;
  logic             first_r;
  logic [Q_W-1:0]   q_r;

  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  logic [8:0]  bscale;
  logic [16:0] mp_r;
  logic [16:0] mp_g;
  logic [16:0] mp_b;
  logic [17:0] sp;
  logic [16:0] ep_r;
  logic [16:0] ep_g;
  logic [16:0] ep_b;
  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_nxt;
  logic [EST_PROD_W-1:0] est_prod;

  logic              div_start;
  logic [DIV_NW-1:0] div_dividend;
  logic [DIV_DW-1:0] div_divisor;
  logic              div_busy;
  logic [DIV_NW-1:0] div_quo;

  logic [Q_W-1:0]   q;
  logic [EST_W-1:0] est;
  logic [15:0]      est_sat;
  logic             over;
  logic [15:0]      room;
  logic [8:0]       fscale_cap;

  logic        status_pix;
  logic [7:0]  go;
  logic [7:0]  ro;
  logic [7:0]  bo;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= 8'd255;
      budget_r     <= 16'd0;
      gamma_en_r   <= 1'b1;
      status_en_r  <= 1'b0;
      error_flag_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BRIGHTNESS: brightness_r <= cfg_data[7:0];
        REG_BUDGET:     budget_r     <= cfg_data;
        REG_GAMMA_EN:   gamma_en_r   <= cfg_data[0];
        REG_STATUS_EN:  status_en_r  <= cfg_data[0];
        REG_ERROR_FLAG: error_flag_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign bscale = {1'b0, brightness_r} + 9'd1;

  assign mp_r = 17'(red_r) * 17'(bscale);
  assign mp_g = 17'(grn_r) * 17'(bscale);
  assign mp_b = 17'(blu_r) * 17'(bscale);
  assign sp   = 18'(bscale) * 18'(frame_scale_r);

  assign ep_r = 17'(red_r) * 17'(scale_r);
  assign ep_g = 17'(grn_r) * 17'(scale_r);
  assign ep_b = 17'(blu_r) * 17'(scale_r);

  assign sum_ext = (SUM_W+1)'(sum_r) + (SUM_W+1)'(pix_sum_r);
  assign sum_nxt = (sum_ext > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];

  // frame end arithmetic
  assign est_prod = EST_PROD_W'(sum_r) * EST_PROD_W'(EST_RECIP);

  assign q       = q_r;
  assign est     = EST_W'(cnt_r) + EST_W'(q);
  assign est_sat = (est > EST_W'(16'hFFFF)) ? 16'hFFFF : est[15:0];
  assign over    = (budget_r != 16'd0) && (est > EST_W'(budget_r));
  assign room    = (budget_r > 16'(cnt_r)) ? (budget_r - 16'(cnt_r)) : 16'd0;
  assign fscale_cap = (div_quo > DIV_NW'(FSCALE_FULL)) ? FSCALE_FULL : div_quo[8:0];

  assign div_start    = cmd.eval & over;
  assign div_dividend = {(DIV_NW-24)'(0), room, 8'd0};
  assign div_divisor  = (q == '0) ? DIV_DW'(1) : DIV_DW'(q);

  lfpl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // pixel output
  assign status_pix = status_en_r && first_r;

  always_comb begin
    if (status_pix) begin
      if (error_flag_r) begin
        ro = gamma_lut(STAT_ERR_R);
        go = gamma_lut(STAT_ERR_G);
        bo = gamma_lut(STAT_ERR_B);
      end else begin
        ro = gamma_lut(STAT_OK_R);
        go = gamma_lut(STAT_OK_G);
        bo = gamma_lut(STAT_OK_B);
      end
    end else if (gamma_en_r) begin
      ro = gamma_lut(ch_r_r);
      go = gamma_lut(ch_g_r);
      bo = gamma_lut(ch_b_r);
    end else begin
      ro = ch_r_r;
      go = ch_g_r;
      bo = ch_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_tuser;
      last_r <= in_tlast;
      red_r  <= in_tdata[7:0];
      grn_r  <= in_tdata[15:8];
      blu_r  <= in_tdata[23:16];
    end
    if (cmd.step1) begin
      pix_sum_r <= 10'(mp_r[15:8]) + 10'(mp_g[15:8]) + 10'(mp_b[15:8]);
      scale_r   <= sp[16:8];
    end
    if (cmd.step2) begin
      ch_r_r <= ep_r[15:8];
      ch_g_r <= ep_g[15:8];
      ch_b_r <= ep_b[15:8];
    end
    if (cmd.div_a) begin
      q_r <= est_prod[EST_SHIFT +: Q_W];
    end
    if (cmd.load_pix) begin
      out_data_r <= {OUT_PAD_W'(0), 1'b0, 16'd0, go, ro, bo};
      out_user_r <= 1'b0;
    end else if (cmd.load_rep) begin
      out_data_r <= {OUT_PAD_W'(0), limited_r, est_r, 24'd0};
      out_user_r <= 1'b1;
    end
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r         <= '0;
      sum_r         <= '0;
      frame_scale_r <= FSCALE_FULL;
      est_r         <= 16'd0;
      limited_r     <= 1'b0;
      first_r       <= 1'b1;
    end else begin
      if (cmd.accum && (cnt_r < CNT_W'(MAX_PIXELS))) begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_nxt;
      end
      if (cmd.eval) begin
        est_r     <= over ? budget_r : est_sat;
        limited_r <= over;
        cnt_r     <= '0;
        sum_r     <= '0;
        first_r   <= 1'b1;
      end else if (cmd.load_pix) begin
        first_r <= last_r;
      end
      if (cmd.load_rep) begin
        frame_scale_r <= limited_r ? fscale_cap : FSCALE_FULL;
      end
    end
  end

  assign sts.op       = op_r;
  assign sts.last     = last_r;
  assign sts.div_busy = div_busy;
  assign sts.over     = over;

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

`default_nettype wire

// File: src/lfpl_ctrl.sv
// Controller state machine: sequences each item through the datapath and owns the result handshake.
// Depends on lfpl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none

`include "led_frame_power_limit_gamma_core_assert.svh"

module lfpl_ctrl
  import lfpl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  output logic      out_tvalid,
  input  logic      out_tready,
  input  lfpl_sts_t sts,
  output lfpl_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_STEP1  = 4'd1;
  localparam logic [3:0] ST_STEP2  = 4'd2;
  localparam logic [3:0] ST_PIXEL  = 4'd3;
  localparam logic [3:0] ST_DIVA   = 4'd4;
  localparam logic [3:0] ST_EVAL   = 4'd5;
  localparam logic [3:0] ST_WAITB  = 4'd6;
  localparam logic [3:0] ST_REPORT = 4'd7;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_STEP1;
        end
      end
      ST_STEP1: begin
        cmd.step1 = 1'b1;
        state_nxt = ST_STEP2;
      end
      ST_STEP2: begin
        if (sts.op == OP_MEASURE) begin
          cmd.accum = 1'b1;
          state_nxt = sts.last ? ST_DIVA : ST_IDLE;
        end else begin
          cmd.step2 = 1'b1;
          state_nxt = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (out_free) begin
          cmd.load_pix = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_DIVA: begin
        cmd.div_a = 1'b1;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = sts.over ? ST_WAITB : ST_REPORT;
      end
      ST_WAITB: begin
        if (!sts.div_busy) begin
          state_nxt = ST_REPORT;
        end
      end
      ST_REPORT: begin
        if (out_free) begin
          cmd.load_rep = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_pix || cmd.load_rep) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  `LFPL_ASSERT_IMPL(a_div_idle, state_r == ST_IDLE, !sts.div_busy,
                    "divider busy while controller idle")
  `LFPL_ASSERT_NEXT(a_div_b_start, (state_r == ST_EVAL) && sts.over,
                    sts.div_busy && (state_r == ST_WAITB),
                    "power scale division not started")
  `LFPL_ASSERT_IMPL(a_out_src, $rose(out_valid_r),
                    ($past(state_r) == ST_PIXEL) || ($past(state_r) == ST_REPORT),
                    "result loaded outside a result state")
  `LFPL_ASSERT_IMPL(a_div_len, (state_r == ST_EVAL) && sts.over,
                    ##(DIV_NW + 1) !sts.div_busy,
                    "divider exceeded its step count")

endmodule

`default_nettype wire

// File: src/led_frame_power_limit_gamma_core.sv
// Frame power limiter and gamma core. Takes one item at a time. Measure pixel: no result.
// Emit pixel: result registered from the PIXEL state; a stalled result holds the input off.
// Frame end report: registered from the REPORT state, reached from the last measure pixel
// through DIVA, EVAL and, when the budget limits, WAITB for the 26-step power scale divider.
// Reset (rst_n low, synchronous) restores register defaults; the gamma table is constant.
`timescale 1ns / 1ps
`default_nettype none

module led_frame_power_limit_gamma_core
  import lfpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                  in_tuser,   // op
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // wire_grb[23:0], current_estimate_ma[39:24],
                                            // power_limited[40], zero[47:41]
  output logic                  out_tuser   // frame_report
);

  lfpl_cmd_t cmd;
  lfpl_sts_t sts;

  assign cfg_ready = 1'b1;

  lfpl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  lfpl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_led_frame_power_limit_gamma_core.sv
// Testbench for led_frame_power_limit_gamma_core: measure and emit passes under changing
// settings, results checked in order against a scoreboard with its own pixel predictor.
// Depends on lfpl_pkg and the core RTL only.
`timescale 1ns / 1ps

typedef struct packed {
  logic [23:0] grb;
  logic [15:0] est_ma;
  logic        limited;
  logic        report;
} led_result_t;

class led_power_scoreboard;
  logic [7:0]  curve[256];
  logic [7:0]  bright;
  logic [15:0] budget_ma;
  logic        gamma_on;
  logic        status_on;
  logic        err_on;
  int unsigned px_count;
  int unsigned ch_sum;
  int unsigned pwr_scale;
  int unsigned est_latched;
  logic        lim_latched;
  logic        pass_start;
  led_result_t awaited[$];
  int          fail_count;

  function new();
    logic [127:0] pow255_8;
    logic [127:0] lhs;
    logic [127:0] rhs;
    int g;
    int n;
    pow255_8 = 128'd1;
    for (n = 0; n < 8; n++) pow255_8 = pow255_8 * 128'd255;
    g = 0;
    for (int v = 0; v < 256; v++) begin
      rhs = 128'd32;
      for (n = 0; n < 13; n++) rhs = rhs * 128'(v);
      while (g < 255) begin
        lhs = pow255_8;
        for (n = 0; n < 5; n++) lhs = lhs * 128'(2 * g + 1);
        if (lhs > rhs) break;
        g++;
      end
      curve[v] = 8'(g);
    end
    bright = 8'd255;
    budget_ma = 16'd0;
    gamma_on = 1'b1;
    status_on = 1'b0;
    err_on = 1'b0;
    px_count = 0;
    ch_sum = 0;
    pwr_scale = 256;
    est_latched = 0;
    lim_latched = 1'b0;
    pass_start = 1'b1;
    fail_count = 0;
  endfunction

  function void set_reg(input logic [lfpl_pkg::CFG_IDX_W-1:0] idx,
                        input logic [lfpl_pkg::CFG_DATA_W-1:0] val);
    case (idx)
      lfpl_pkg::REG_BRIGHTNESS: bright = val[7:0];
      lfpl_pkg::REG_BUDGET:     budget_ma = val;
      lfpl_pkg::REG_GAMMA_EN:   gamma_on = val[0];
      lfpl_pkg::REG_STATUS_EN:  status_on = val[0];
      lfpl_pkg::REG_ERROR_FLAG: err_on = val[0];
      default: ;
    endcase
  endfunction

  function void note_pixel(input logic op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b, input logic last);
    int unsigned bscale;
    int unsigned est;
    int unsigned room;
    int unsigned used;
    int unsigned ps;
    int unsigned scale;
    logic [7:0]  ro;
    logic [7:0]  go;
    logic [7:0]  bo;
    led_result_t res;
    bscale = int'(bright) + 1;
    if (op == lfpl_pkg::OP_MEASURE) begin
      if (px_count < lfpl_pkg::MAX_PIXELS) begin
        px_count++;
        ch_sum += ((r * bscale) >> 8) + ((g * bscale) >> 8) + ((b * bscale) >> 8);
        if (ch_sum > 32'h1FFFFF) ch_sum = 32'h1FFFFF;
      end
      if (!last) return;
      est = px_count + (ch_sum * 20) / 255;
      est_latched = (est > 65535) ? 65535 : est;
      pwr_scale = 256;
      lim_latched = 1'b0;
      if (budget_ma != 0 && est > budget_ma) begin
        room = (budget_ma > px_count) ? budget_ma - px_count : 0;
        used = est - px_count;
        ps = (room * 256) / ((used != 0) ? used : 1);
        pwr_scale = (ps > 256) ? 256 : ps;
        lim_latched = 1'b1;
        est_latched = budget_ma;
      end
      px_count = 0;
      ch_sum = 0;
      pass_start = 1'b1;
      res.grb = '0;
      res.est_ma = est_latched[15:0];
      res.limited = lim_latched;
      res.report = 1'b1;
    end else begin
      if (status_on && pass_start) begin
        if (err_on) begin
          ro = curve[lfpl_pkg::STAT_ERR_R];
          go = curve[lfpl_pkg::STAT_ERR_G];
          bo = curve[lfpl_pkg::STAT_ERR_B];
        end else begin
          ro = curve[lfpl_pkg::STAT_OK_R];
          go = curve[lfpl_pkg::STAT_OK_G];
          bo = curve[lfpl_pkg::STAT_OK_B];
        end
      end else begin
        scale = (bscale * pwr_scale) >> 8;
        ro = 8'((r * scale) >> 8);
        go = 8'((g * scale) >> 8);
        bo = 8'((b * scale) >> 8);
        if (gamma_on) begin
          ro = curve[ro];
          go = curve[go];
          bo = curve[bo];
        end
      end
      pass_start = last;
      res.grb = {go, ro, bo};
      res.est_ma = '0;
      res.limited = 1'b0;
      res.report = 1'b0;
    end
    awaited.push_back(res);
  endfunction

  function void check_output(input logic [lfpl_pkg::OUT_DATA_W-1:0] tdata,
                             input logic tuser);
    led_result_t want;
    if (awaited.size() == 0) begin
      $error("result with nothing awaited: tdata %h tuser %b", tdata, tuser);
      fail_count++;
      return;
    end
    want = awaited.pop_front();
    if (tdata[23:0] !== want.grb) begin
      $error("wire_grb expected %h actual %h", want.grb, tdata[23:0]);
      fail_count++;
    end
    if (tdata[39:24] !== want.est_ma) begin
      $error("current_estimate_ma expected %0d actual %0d", want.est_ma, tdata[39:24]);
      fail_count++;
    end
    if (tdata[40] !== want.limited) begin
      $error("power_limited expected %b actual %b", want.limited, tdata[40]);
      fail_count++;
    end
    if (tuser !== want.report) begin
      $error("frame_report expected %b actual %b", want.report, tuser);
      fail_count++;
    end
  endfunction

  function int pending();
    return awaited.size();
  endfunction
endclass

module tb_led_frame_power_limit_gamma_core;
  import lfpl_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 1000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  led_power_scoreboard sb = new();

  int burst_left = 1;
  int gap_max = 4;
  int rx_mode = 0;
  int rx_period = 5;
  int rx_stall = 2;
  int rx_tick = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;

  led_frame_power_limit_gamma_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  initial begin
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

  always @(negedge clk) begin
    rx_tick++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready = 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready = 1'b1;
        1: out_tready = ($urandom_range(0, 3) != 0);
        default: out_tready = ((rx_tick % rx_period) < (rx_period - rx_stall));
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_output(out_tdata, out_tuser);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] bright, input logic [15:0] budget,
                            input logic gam, input logic stat, input logic err);
    write_reg(REG_BRIGHTNESS, 16'(bright));
    write_reg(REG_BUDGET, budget);
    write_reg(REG_GAMMA_EN, 16'(gam));
    write_reg(REG_STATUS_EN, 16'(stat));
    write_reg(REG_ERROR_FLAG, 16'(err));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_pixel(input logic op, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    int gap;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {b, g, r};
    in_tuser = op;
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    sb.note_pixel(op, r, g, b, last);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_pass(input logic op, input int n, input int noise_pct);
    logic opx;
    logic lastx;
    for (int i = 0; i < n; i++) begin
      opx = op;
      lastx = (i == n - 1);
      if ($urandom_range(0, 99) < noise_pct) begin
        opx = 1'($urandom);
        lastx = 1'($urandom);
      end
      send_pixel(opx, pick_channel(), pick_channel(), pick_channel(), lastx);
    end
  endtask

  initial begin
    int sent;
    int n;
    int phase;
    logic [7:0]  bright;
    logic [15:0] budget;
    sent = 0;
    phase = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_pixel(OP_MEASURE, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(OP_MEASURE, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(OP_MEASURE, 8'd1, 8'd128, 8'd254, 1'b1);
    send_pixel(OP_EMIT, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(OP_EMIT, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(OP_EMIT, 8'd1, 8'd128, 8'd254, 1'b1);
    wait_idle();
    set_config(8'd255, 16'd0, 1'b0, 1'b1, 1'b0);
    send_pixel(OP_EMIT, 8'd10, 8'd20, 8'd30, 1'b0);
    send_pixel(OP_EMIT, 8'd200, 8'd100, 8'd50, 1'b1);
    wait_idle();
    set_config(8'd255, 16'd0, 1'b1, 1'b1, 1'b1);
    send_pixel(OP_EMIT, 8'd1, 8'd2, 8'd3, 1'b0);
    send_pixel(OP_EMIT, 8'd255, 8'd255, 8'd255, 1'b1);
    wait_idle();
    set_config(8'd0, 16'd1, 1'b1, 1'b0, 1'b0);
    send_pixel(OP_MEASURE, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(OP_MEASURE, 8'd0, 8'd0, 8'd0, 1'b1);
    send_pixel(OP_EMIT, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(OP_MEASURE, 8'd255, 8'd0, 8'd0, 1'b0);
    send_pixel(OP_EMIT, 8'd0, 8'd255, 8'd0, 1'b0);
    send_pixel(OP_MEASURE, 8'd0, 8'd0, 8'd255, 1'b1);
    send_pixel(OP_EMIT, 8'd128, 8'd64, 8'd32, 1'b1);
    wait_idle();

    gap_max = 0;
    set_config(8'd255, 16'd0, 1'b1, 1'b0, 1'b0);
    for (int i = 0; i < MAX_PIXELS + 2; i++)
      send_pixel(OP_MEASURE, 8'd255, 8'd255, 8'd255, i == MAX_PIXELS + 1);
    send_pixel(OP_EMIT, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(OP_EMIT, 8'd100, 8'd50, 8'd25, 1'b1);
    wait_idle();

    while (sent < RANDOM_ITEMS) begin
      case (phase % 4)
        0: bright = 8'd0;
        1: bright = 8'd255;
        default: bright = 8'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: budget = 16'd0;
        1: budget = 16'($urandom_range(1, 200));
        2: budget = (phase % 2 == 0) ? 16'd65535 : 16'd1;
        default: budget = 16'($urandom);
      endcase
      set_config(bright, budget, 1'($urandom), 1'($urandom), 1'($urandom));
      gap_max = (phase % 3 == 0) ? 0 : $urandom_range(1, 8);
      rx_mode = phase % 3;
      rx_period = $urandom_range(2, 9);
      rx_stall = $urandom_range(1, rx_period - 1);
      for (int f = 0; f < 8 && sent < RANDOM_ITEMS; f++) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        send_pass(OP_MEASURE, n, 5);
        if (phase == 2 && f == 0) begin
          n = 60;
          hold_req = 1'b1;
        end
        send_pass(OP_EMIT, n, 5);
        sent += 2 * n;
      end
      wait_idle();
      phase++;
    end

    @(negedge clk);
    in_tvalid = 1'b0;
    wait_idle();
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.fail_count++;
    end
    if (sb.fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+src
src/lfpl_pkg.sv
src/lfpl_div.sv
src/lfpl_dp.sv
src/lfpl_ctrl.sv
src/led_frame_power_limit_gamma_core.sv
tb/sv/tb_led_frame_power_limit_gamma_core.sv
